// File: rtl/wppt_pkg.sv
package wppt_pkg;

  // fixed field widths
  localparam int unsigned TIMER_W = 16;
  localparam int unsigned NUM_W = 24;
  localparam int unsigned VEL_W = 25;
  localparam int unsigned HELD_OUT_W = 7;

  // wheel inputs that exist behind the one-bit wheel index
  localparam int unsigned NUM_WHEEL_INPUTS = 2;
  localparam int unsigned WHEELS = 2;

  // default bound on stored periods per wheel
  localparam int unsigned MAX_PERIODS_DEFAULT = 64;

  // speed numerator after reset, Q.8 2*pi / (pulses per rev * tick)
  localparam logic [NUM_W-1:0] NUMERATOR_RESET = 24'd409045;

  // magnitude used when the mean period truncates to zero
  localparam logic [NUM_W-1:0] VEL_MAX = 24'hFFFFFF;

  // request kinds
  typedef enum logic [1:0] {
    REQ_PULSE  = 2'd0,
    REQ_SAMPLE = 2'd1,
    REQ_ZERO   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV1 = 4'b0010,
    ST_DIV2 = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

endpackage

// File: rtl/wheel_pulse_period_tachometer.sv
// Two-wheel period tachometer. Pulse-edge and zero items only update per-wheel
// state. A sample item runs up to two divisions through one shared restoring
// divider, 24 quotient bits each at one bit per cycle: mean period = period sum /
// period count, then velocity = speed_numerator / mean period. A sample passes
// through accept, divider steps and result load; with no periods, a zero sum or
// the stopped flag it skips the divisions. The input is not ready while a sample
// is being worked on; a finished result waits in the output register while new
// items are taken. speed_numerator may only be written while the block is idle.
module wheel_pulse_period_tachometer #(
  parameter int unsigned MAX_PERIODS = wppt_pkg::MAX_PERIODS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // input beats
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // wheel, timer_count[15:0], direction_negative,
                                 // motors_stopped, zero fill
  input  logic [1:0]  s_tuser,   // req_type
  // result beats
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // out_wheel, angular_velocity[24:0],
                                 // periods_averaged[6:0], zero fill
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data   // speed_numerator
);
  import wppt_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_PERIODS + 1);
  localparam int unsigned SUM_W = $clog2(MAX_PERIODS * 65535 + 1);
  localparam int unsigned DIV_W = NUM_W;
  localparam int unsigned STEP_W = $clog2(DIV_W);

  // input field split
  logic               in_wheel;
  logic [TIMER_W-1:0] in_timer;
  logic               in_neg;
  logic               in_stopped;
  req_t               in_req;

  assign in_wheel   = s_tdata[0];
  assign in_timer   = s_tdata[16:1];
  assign in_neg     = s_tdata[17];
  assign in_stopped = s_tdata[18];
  assign in_req     = req_t'(s_tuser);

  // per-wheel state
  logic               awaiting_end [WHEELS];
  logic [TIMER_W-1:0] start_count  [WHEELS];
  logic [SUM_W-1:0]   period_sum   [WHEELS];
  logic [CNT_W-1:0]   period_count [WHEELS];

  logic [NUM_W-1:0] speed_numerator;

  state_t state;

  // divider and job registers
  logic [DIV_W-1:0]   quo;
  logic [TIMER_W-1:0] rem;
  logic [TIMER_W-1:0] divisor;
  logic [STEP_W-1:0]  step;
  logic               job_wheel;
  logic               job_neg;
  logic [CNT_W-1:0]   job_held;
  logic [NUM_W-1:0]   job_mag;

  // output register
  logic                  out_wheel;
  logic [VEL_W-1:0]      angular_velocity;
  logic [HELD_OUT_W-1:0] periods_averaged;

  logic accept;
  logic wheel_ok;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign wheel_ok  = (32'(in_wheel) < NUM_WHEEL_INPUTS);

  // one restoring divider step
  logic [TIMER_W:0]   rem_sh;
  logic               q_bit;
  logic [TIMER_W-1:0] rem_next;
  logic [DIV_W-1:0]   quo_next;
  logic [TIMER_W:0]   rem_diff;

  always_comb begin
    rem_sh   = {rem, quo[DIV_W-1]};
    rem_diff = rem_sh - {1'b0, divisor};
    q_bit    = (rem_sh >= {1'b0, divisor});
    rem_next = q_bit ? rem_diff[TIMER_W-1:0] : rem_sh[TIMER_W-1:0];
    quo_next = {quo[DIV_W-2:0], q_bit};
  end

  // values seen on a sample beat
  logic [CNT_W-1:0] smp_held;
  logic [SUM_W-1:0] smp_sum;
  logic [TIMER_W-1:0] pulse_period;

  always_comb begin
    smp_held = in_stopped ? '0 : period_count[in_wheel];
    smp_sum  = in_stopped ? '0 : period_sum[in_wheel];
    pulse_period = in_timer - start_count[in_wheel];
  end

  logic [7:0] held_ext;
  assign held_ext = 8'(job_held);

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_numerator <= NUMERATOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      speed_numerator <= cfg_data;
    end
  end

  // per-wheel state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WHEELS; i++) begin
        awaiting_end[i] <= 1'b0;
        start_count[i]  <= '0;
        period_sum[i]   <= '0;
        period_count[i] <= '0;
      end
    end else if (accept && wheel_ok) begin
      unique case (in_req)
        REQ_PULSE: begin
          if (!awaiting_end[in_wheel]) begin
            start_count[in_wheel]  <= in_timer;
            awaiting_end[in_wheel] <= 1'b1;
          end else begin
            if (period_count[in_wheel] < CNT_W'(MAX_PERIODS)) begin
              period_sum[in_wheel]   <= period_sum[in_wheel] + SUM_W'(pulse_period);
              period_count[in_wheel] <= period_count[in_wheel] + 1'b1;
            end
            awaiting_end[in_wheel] <= 1'b0;
          end
        end
        REQ_SAMPLE: begin
          if (in_stopped) begin
            awaiting_end[in_wheel] <= 1'b0;
          end
          period_sum[in_wheel]   <= '0;
          period_count[in_wheel] <= '0;
        end
        REQ_ZERO: begin
          awaiting_end[in_wheel] <= 1'b0;
          period_sum[in_wheel]   <= '0;
          period_count[in_wheel] <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && wheel_ok && in_req == REQ_SAMPLE) begin
            if (smp_held == '0 || smp_sum == '0) begin
              state <= ST_FIN;
            end else begin
              state <= ST_DIV1;
            end
          end
        end
        ST_DIV1: begin
          if (step == STEP_W'(DIV_W - 1)) begin
            if (quo_next[TIMER_W-1:0] == '0) begin
              state <= ST_FIN;
            end else begin
              state <= ST_DIV2;
            end
          end
        end
        ST_DIV2: begin
          if (step == STEP_W'(DIV_W - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // divider datapath and job registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        job_wheel <= in_wheel;
        job_neg   <= in_neg;
        job_held  <= smp_held;
        job_mag   <= '0;
        quo       <= DIV_W'(smp_sum);
        rem       <= '0;
        divisor   <= TIMER_W'(smp_held);
        step      <= '0;
      end
      ST_DIV1: begin
        step <= step + 1'b1;
        if (step == STEP_W'(DIV_W - 1)) begin
          // mean period is ready, start numerator / mean
          step    <= '0;
          quo     <= speed_numerator;
          rem     <= '0;
          divisor <= quo_next[TIMER_W-1:0];
          job_mag <= VEL_MAX;
        end else begin
          quo <= quo_next;
          rem <= rem_next;
        end
      end
      ST_DIV2: begin
        step <= step + 1'b1;
        quo  <= quo_next;
        rem  <= rem_next;
        if (step == STEP_W'(DIV_W - 1)) begin
          job_mag <= quo_next;
        end
      end
      ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      out_wheel        <= job_wheel;
      angular_velocity <= job_neg ? (VEL_W'(0) - VEL_W'(job_mag)) : VEL_W'(job_mag);
      periods_averaged <= held_ext[HELD_OUT_W-1:0];
    end
  end

  assign m_tdata = {7'd0, periods_averaged, angular_velocity, out_wheel};

endmodule
